// ===== design/lzwc_pkg.sv =====
// Shared types and constants of the 12-bit LZW compressor.
package lzwc_pkg;

	localparam int DICT_SIZE_DEF = 4096;
	localparam int CODE_BITS     = 12;
	localparam int KEY_BITS      = CODE_BITS + 8;
	localparam int ACC_BITS      = CODE_BITS + 7;
	localparam int CNT_BITS      = 5;
	localparam int NFC_BITS      = CODE_BITS + 1;

	localparam logic [CODE_BITS-1:0] CODE_CLR   = 12'd256;
	localparam logic [CODE_BITS-1:0] FIRST_FREE = 12'd257;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       run_end;
		logic       stream_end;
	} out_item_t;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic accept;      // latch the incoming byte, form key and hash slot
		logic first;       // byte becomes the prefix of a new string
		logic tab_rd;      // read hash table at current slot
		logic dict_rd;     // read dictionary at code from hash table
		logic step;        // advance to next probe slot
		logic hit;         // extended string found
		logic miss;        // extended string not found
		logic push_clear;  // pack CLEAR code
		logic push_final;  // pack final prefix code
		logic emit;        // move one whole byte to the output register
		logic pad;         // move the zero-padded tail to the output register
		logic run_end;
		logic stream_end;
		logic restart;     // return to reset state after the last byte
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic have_prefix;
		logic slot_valid;
		logic key_match;
		logic dict_full;
		logic cnt_ge8;
		logic cnt_ge16;
		logic cnt_is8;
		logic cnt_nz;
		logic out_free;
		logic in_last;     // last flag of the byte on offer
	} sts_t;

endpackage

// ===== design/lzwc_ctrl.sv =====
// Controller state machine: lookup sequencing, code packing and byte emission.
module lzwc_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  lzwc_pkg::sts_t sts,
	output lzwc_pkg::cmd_t cmd
);
	import lzwc_pkg::*;

	typedef enum logic [2:0] {
		S_IDLE, S_TAB, S_DICT, S_CMP, S_DRAIN
	} state_t;

	state_t state_q;
	logic   last_q, clr_pend_q, fin_pend_q;
	logic   accept, more;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	// further output bytes still owed after the one being emitted
	assign more = clr_pend_q || fin_pend_q || sts.cnt_ge16 || (last_q && !sts.cnt_is8);

	// command decode
	always_comb begin
		cmd = '0;
		cmd.accept = accept;
		cmd.first  = accept && !sts.have_prefix;
		unique case (state_q)
			S_IDLE: begin
			end
			S_TAB:  cmd.tab_rd = 1'b1;
			S_DICT: cmd.dict_rd = 1'b1;
			S_CMP: begin
				if (sts.slot_valid && sts.key_match) cmd.hit = 1'b1;
				else if (sts.slot_valid)             cmd.step = 1'b1;
				else                                 cmd.miss = 1'b1;
			end
			S_DRAIN: begin
				if (sts.cnt_ge8) begin
					cmd.emit       = sts.out_free;
					cmd.run_end    = !more;
					cmd.stream_end = last_q && !more;
				end else if (clr_pend_q) begin
					cmd.push_clear = 1'b1;
				end else if (fin_pend_q) begin
					cmd.push_final = 1'b1;
				end else if (last_q && sts.cnt_nz) begin
					cmd.pad        = sts.out_free;
					cmd.run_end    = 1'b1;
					cmd.stream_end = 1'b1;
				end else begin
					cmd.restart = last_q;
				end
			end
			default: begin
			end
		endcase
	end

	// state and pending flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			last_q     <= 1'b0;
			clr_pend_q <= 1'b0;
			fin_pend_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					// the last flag and final-code request are taken with the item
					if (accept) begin
						last_q     <= sts.in_last;
						fin_pend_q <= sts.in_last;
						clr_pend_q <= 1'b0;
						state_q    <= sts.have_prefix ? S_TAB : S_DRAIN;
					end
				end
				S_TAB:  state_q <= S_DICT;
				S_DICT: state_q <= S_CMP;
				S_CMP: begin
					if (cmd.step) begin
						state_q <= S_TAB;
					end else begin
						clr_pend_q <= cmd.miss && sts.dict_full;
						state_q    <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					if (cmd.push_clear) clr_pend_q <= 1'b0;
					if (cmd.push_final) fin_pend_q <= 1'b0;
					if (!sts.cnt_ge8 && !clr_pend_q && !fin_pend_q &&
					    !(last_q && sts.cnt_nz))
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== design/lzwc_dpath.sv =====
// Datapath: hash table, dictionary memory, bit packer and output register.
module lzwc_dpath #(
	parameter int DICT_SIZE = lzwc_pkg::DICT_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  lzwc_pkg::in_item_t in_data,
	input  lzwc_pkg::cmd_t     cmd,
	output lzwc_pkg::sts_t     sts,
	output logic               out_valid,
	input  logic               out_ready,
	output lzwc_pkg::out_item_t out_data
);
	import lzwc_pkg::*;

	localparam int SW  = $clog2(DICT_SIZE);
	localparam int TAB = 1 << SW;
	localparam int DW  = KEY_BITS + SW;

	logic [CODE_BITS-1:0] tab_mem [TAB];
	logic [DW-1:0]        dict_mem [DICT_SIZE];

	logic [7:0]           byte_q;
	logic [KEY_BITS-1:0]  key_q;
	logic [SW-1:0]        slot_q;
	logic [CODE_BITS-1:0] prefix_q;
	logic                 have_q;
	logic [NFC_BITS-1:0]  nfc_q;
	logic [ACC_BITS-1:0]  acc_q;
	logic [CNT_BITS-1:0]  cnt_q;
	logic [CODE_BITS-1:0] tab_q;
	logic [DW-1:0]        dict_q;
	logic                 out_valid_q;
	out_item_t            out_q;

	logic [SW-1:0]        hash;
	logic                 full, push;
	logic [CODE_BITS-1:0] push_code;
	logic [ACC_BITS-1:0]  emit_word, pad_word;

	assign hash = SW'(prefix_q) ^ (SW'(in_data.in_byte) << (SW - 8));
	assign full = nfc_q >= NFC_BITS'(DICT_SIZE);
	assign push = cmd.miss || cmd.push_clear || cmd.push_final;
	assign push_code = cmd.push_clear ? CODE_CLR : prefix_q;
	assign emit_word = acc_q >> (cnt_q - CNT_BITS'(8));
	assign pad_word  = acc_q << (CNT_BITS'(8) - cnt_q);

	// status
	always_comb begin
		sts.have_prefix = have_q;
		sts.slot_valid  = (tab_q >= FIRST_FREE) && ({1'b0, tab_q} < nfc_q) &&
		                  (dict_q[SW-1:0] == slot_q);
		sts.key_match   = dict_q[DW-1:SW] == key_q;
		sts.dict_full   = full;
		sts.cnt_ge8     = cnt_q >= CNT_BITS'(8);
		sts.cnt_ge16    = cnt_q >= CNT_BITS'(16);
		sts.cnt_is8     = cnt_q == CNT_BITS'(8);
		sts.cnt_nz      = cnt_q != '0;
		sts.out_free    = !out_valid_q || out_ready;
		sts.in_last     = in_data.in_last;
	end

	// memories: registered reads, insert on a miss while the dictionary is not full
	always_ff @(posedge clk) begin
		if (cmd.tab_rd)  tab_q  <= tab_mem[slot_q];
		if (cmd.dict_rd) dict_q <= dict_mem[tab_q[SW-1:0]];
		if (cmd.miss && !full) begin
			tab_mem[slot_q]           <= nfc_q[CODE_BITS-1:0];
			dict_mem[nfc_q[SW-1:0]]   <= {key_q, slot_q};
		end
	end

	// item latch and probe slot
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			byte_q <= in_data.in_byte;
			key_q  <= {prefix_q, in_data.in_byte};
			slot_q <= hash;
		end else if (cmd.step) begin
			slot_q <= slot_q + SW'(1);
		end
	end

	// dictionary state and bit packer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prefix_q <= '0;
			have_q   <= 1'b0;
			nfc_q    <= NFC_BITS'(FIRST_FREE);
			acc_q    <= '0;
			cnt_q    <= '0;
		end else if (cmd.restart) begin
			prefix_q <= '0;
			have_q   <= 1'b0;
			nfc_q    <= NFC_BITS'(FIRST_FREE);
			cnt_q    <= '0;
		end else begin
			if (cmd.first) begin
				prefix_q <= CODE_BITS'(in_data.in_byte);
				have_q   <= 1'b1;
			end
			if (cmd.hit)  prefix_q <= tab_q;
			if (cmd.miss) begin
				prefix_q <= CODE_BITS'(byte_q);
				nfc_q    <= full ? NFC_BITS'(FIRST_FREE) : nfc_q + NFC_BITS'(1);
			end
			if (push) begin
				acc_q <= {acc_q[6:0], push_code};
				cnt_q <= cnt_q + CNT_BITS'(CODE_BITS);
			end else if (cmd.emit) begin
				cnt_q <= cnt_q - CNT_BITS'(8);
			end else if (cmd.pad) begin
				cnt_q <= '0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.pad) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit || cmd.pad) begin
			out_q.out_byte   <= cmd.pad ? pad_word[7:0] : emit_word[7:0];
			out_q.run_end    <= cmd.run_end;
			out_q.stream_end <= cmd.stream_end;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ===== design/lzw_compressor_12bit.sv =====
// LZW compressor with fixed 12-bit codes packed MSB first into bytes.
// One input byte is taken at a time; in_ready is high only while idle.
// The transfer is followed by a hash-table probe in three steps
// (table read, dictionary read, compare) and then the drain state; a
// collision repeats the probe at the next slot. Packing the CLEAR code or
// the final code and moving each output byte are done in the drain state,
// which waits while the output is stalled. The first byte of a stream
// skips the probe and goes straight to the drain state.
// The dictionary and its hash table need no clearing after reset: an entry
// is trusted only if its code lies below the next free code and points back
// to the slot it was found in.
module lzw_compressor_12bit #(
	parameter int DICT_SIZE = lzwc_pkg::DICT_SIZE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  lzwc_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output lzwc_pkg::out_item_t out_data
);
	import lzwc_pkg::*;

	cmd_t cmd;
	sts_t sts;

	lzwc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lzwc_dpath #(.DICT_SIZE(DICT_SIZE)) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

endmodule

// ===== design/lzwc_checker.sv =====
// Port-level checks of the LZW compressor, bound to the top level.
module lzwc_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input lzwc_pkg::in_item_t  in_data,
	input logic                out_valid,
	input logic                out_ready,
	input lzwc_pkg::out_item_t out_data
);
	// an offered input holds until its transfer
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid && $stable(in_data))
		else $error("input changed while waiting");

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// the end of the stream always closes the item's results
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.stream_end |-> out_data.run_end)
		else $error("stream end without run end");

	// one byte in work at a time
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken while busy");

endmodule

bind lzw_compressor_12bit lzwc_checker u_lzwc_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_data  (out_data)
);
